/* design/stack_with_search_top_macros.svh */
// assertion macros for the stack with search block
// used by stack_with_search_top; expects signals clock and reset in scope
`ifndef STACK_WITH_SEARCH_TOP_MACROS_SVH
`define STACK_WITH_SEARCH_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every edge outside reset
`define STK_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define STK_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define STK_ASSERT_ALWAYS(label, prop, msg)
`define STK_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* design/stk_pkg.sv */
// shared types and codes for the stack with search block
// no dependencies
package stk_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned FUNC_W = 2;
   localparam int unsigned STAT_W = 3;
   localparam int unsigned POS_W  = 5;

   typedef logic signed [DATA_W-1:0] data_type;

   // request operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_PUSHED   = 3'd0;
   localparam logic [STAT_W-1:0] STAT_POPPED   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FOUND    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd4;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd5;

   // shift commands broadcast to every cell of the chain
   typedef struct packed {
      logic shift_down;  // push: take neighbour above
      logic shift_up;    // pop: take neighbour below
      logic rotate;      // search: shift up, tail cell takes the top
   } cell_ctrl_type;

endpackage

/* design/stack_with_search_top.sv */
// top level of the stack with search block: control sequencer and cell chain
// depends on stk_pkg, stk_cell and stack_with_search_top_macros.svh

// Bounded LIFO of DEPTH signed 32-bit words held in a chain of cells, top in
// the first cell. A transaction is taken when start is high and busy is low.
// For push and pop the response strobe rsp_valid rises in the cycle after
// the transaction and busy stays low, so a new transaction may follow at once.
// A search rotates the stored entries through the chain one per cycle and
// compares the top cell with the key, holding busy through the rotation and
// the closing state S_DONE (an empty stack goes straight to S_DONE); each
// match is held until the next match is seen and is then reported, and the
// deepest match or the not-found response comes in the cycle in which busy
// falls. Every response is on the rsp_ ports for exactly one cycle and
// cannot be stalled. An unused operation code is dropped with no response.
// Stored words have no reset; only written entries are read.
`include "stack_with_search_top_macros.svh"

module stack_with_search_top #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [stk_pkg::FUNC_W-1:0]    req_func,
   input  logic signed [stk_pkg::DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   output logic [stk_pkg::STAT_W-1:0]    rsp_status,
   output logic signed [stk_pkg::DATA_W-1:0] rsp_data_out,
   output logic [stk_pkg::POS_W-1:0]     rsp_position,
   output logic                          rsp_last
);
   import stk_pkg::*;

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   step_ff;
   logic [CNT_W-1:0]   step_next;
   data_type           key_ff;
   logic               pend_valid_ff;
   logic [CNT_W-1:0]   pend_pos_ff;
   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   data_type           rsp_data_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic               rsp_last_ff;

   logic               accept;
   func_type           func;
   logic               full;
   logic               empty;
   logic               top_match;
   cell_ctrl_type      cell_ctrl;
   data_type           cell_value [DEPTH];

   logic               pushpop_accept;
   logic               rsp_found;
   logic               rsp_nonpop;
   logic               rsp_closing;

   assign accept    = start && (state_ff == S_IDLE);
   assign func      = func_type'(req_func);
   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign empty     = (fill_ff == '0);
   assign step_next = step_ff + CNT_W'(1);
   assign top_match = (cell_value[0] == key_ff);

   // shift commands for the chain
   always_comb begin
      cell_ctrl.shift_down = accept && (func == FUNC_PUSH) && !full;
      cell_ctrl.shift_up   = accept && (func == FUNC_POP) && !empty;
      cell_ctrl.rotate     = (state_ff == S_SCAN);
   end

   // chain of cells, index 0 is the top of the stack
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      data_type above;
      data_type below;
      logic     tail;

      if (i == 0) begin : g_first
         assign above = req_value;
      end else begin : g_inner
         assign above = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign below = cell_value[i];
      end else begin : g_lower
         assign below = cell_value[i+1];
      end
      assign tail = (fill_ff == CNT_W'(i + 1));

      stk_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .is_tail    (tail),
         .from_above (above),
         .from_below (below),
         .top_value  (cell_value[0]),
         .value      (cell_value[i])
      );
   end

   // sequencer: state, fill count and registered responses
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  rsp_data_ff <= '0;
                  rsp_pos_ff  <= '0;
                  rsp_last_ff <= 1'b1;
                  unique case (func)
                     FUNC_PUSH: begin
                        rsp_valid_ff <= 1'b1;
                        if (full) begin
                           rsp_status_ff <= STAT_OVERFLOW;
                        end else begin
                           rsp_status_ff <= STAT_PUSHED;
                           fill_ff       <= fill_ff + CNT_W'(1);
                        end
                     end
                     FUNC_POP: begin
                        rsp_valid_ff <= 1'b1;
                        if (empty) begin
                           rsp_status_ff <= STAT_EMPTY;
                        end else begin
                           rsp_status_ff <= STAT_POPPED;
                           rsp_data_ff   <= cell_value[0];
                           fill_ff       <= fill_ff - CNT_W'(1);
                        end
                     end
                     FUNC_SEARCH: begin
                        key_ff        <= req_value;
                        step_ff       <= '0;
                        pend_valid_ff <= 1'b0;
                        state_ff      <= empty ? S_DONE : S_SCAN;
                     end
                     default: begin
                        // unused code: dropped
                     end
                  endcase
               end
            end
            S_SCAN: begin
               // a new match releases the one held before it
               if (top_match) begin
                  if (pend_valid_ff) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= STAT_FOUND;
                     rsp_data_ff   <= '0;
                     rsp_pos_ff    <= POS_W'(pend_pos_ff);
                     rsp_last_ff   <= 1'b0;
                  end
                  pend_valid_ff <= 1'b1;
                  pend_pos_ff   <= step_next;
               end
               step_ff <= step_next;
               if (step_next == fill_ff) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // deepest match or not found closes the search
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= '0;
               rsp_last_ff  <= 1'b1;
               if (pend_valid_ff) begin
                  rsp_status_ff <= STAT_FOUND;
                  rsp_pos_ff    <= POS_W'(pend_pos_ff);
               end else begin
                  rsp_status_ff <= STAT_NOTFOUND;
                  rsp_pos_ff    <= '0;
               end
               pend_valid_ff <= 1'b0;
               state_ff      <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_last     = rsp_last_ff;

   // terms for the checks
   assign pushpop_accept = accept && (func == FUNC_PUSH || func == FUNC_POP);
   assign rsp_found      = rsp_valid && (rsp_status == STAT_FOUND);
   assign rsp_nonpop     = rsp_valid && (rsp_status != STAT_POPPED);
   assign rsp_closing    = rsp_valid && rsp_last && !busy;

   // checks
   `STK_ASSERT_ALWAYS(a_fill_bound, fill_ff <= CNT_W'(DEPTH), "fill count beyond depth")
   `STK_ASSERT_ALWAYS(a_found_pos, !rsp_found || rsp_position != '0, "found without position")
   `STK_ASSERT_ALWAYS(a_data_zero, !rsp_nonpop || rsp_data_out == '0, "data on non-pop response")
   `STK_ASSERT_NEXT(a_pushpop_resp, pushpop_accept, rsp_closing, "push or pop response missing")
   `STK_ASSERT_NEXT(a_search_end, state_ff == S_DONE, rsp_closing, "search did not close")

endmodule

/* design/stk_cell.sv */
// one storage cell of the stack chain
// depends on stk_pkg
module stk_cell (
   input  logic                  clock,
   input  stk_pkg::cell_ctrl_type ctrl,
   input  logic                  is_tail,
   input  stk_pkg::data_type     from_above,
   input  stk_pkg::data_type     from_below,
   input  stk_pkg::data_type     top_value,
   output stk_pkg::data_type     value
);
   import stk_pkg::*;

   data_type value_ff;
   data_type value_in;

   // select the neighbour to load, hold otherwise
   always_comb begin
      priority if (ctrl.shift_down) begin
         value_in = from_above;
      end else if (ctrl.shift_up) begin
         value_in = from_below;
      end else if (ctrl.rotate) begin
         value_in = is_tail ? top_value : from_below;
      end else begin
         value_in = value_ff;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
